@@ rtl/core/task_dependency_scoreboard_unit_macros.svh @@
// Assertion macros shared by the scoreboard checker.
`ifndef TASK_DEPENDENCY_SCOREBOARD_UNIT_MACROS_SVH
`define TASK_DEPENDENCY_SCOREBOARD_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scoreboard check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scoreboard check failed");

`endif

@@ rtl/core/tds_pkg.sv @@
// Package with the types, codes and constants of the task dependency scoreboard.
package tds_pkg;

    localparam int OP_W        = 4;
    localparam int SLOT_W      = 5;
    localparam int HANDLE_W    = 8;
    localparam int RES_W       = 3;
    localparam int CNT_W       = 6;
    localparam int TBL_W       = 6;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam int DEF_NUM_SLOTS   = 32;
    localparam int DEF_NUM_HANDLES = 256;
    localparam int MAX_TBL_DEPTH   = 256;

    localparam logic [TBL_W-1:0] TBL_UNMAPPED = 6'd63;

    // Lifecycle phase of one slot.
    typedef enum logic [2:0] {
        PH_READY     = 3'd0,
        PH_WAITING   = 3'd1,
        PH_FORCED    = 3'd2,
        PH_EXECUTING = 3'd3,
        PH_COMPLETE  = 3'd4,
        PH_DETACHED  = 3'd5
    } phase_t;

    // Result codes.
    typedef enum logic [RES_W-1:0] {
        EV_ALLOC   = 3'd0,
        EV_FULL    = 3'd1,
        EV_WAIT    = 3'd2,
        EV_EXEC    = 3'd3,
        EV_DISPOSE = 3'd4,
        EV_DONE    = 3'd5,
        EV_ERROR   = 3'd6
    } event_t;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_ATTACH       = 4'd0,
        OP_ORDER_SLOTS  = 4'd1,
        OP_ORDER_HANDLE = 4'd2,
        OP_MAP          = 4'd3,
        OP_UNMAP        = 4'd4,
        OP_START        = 4'd5,
        OP_FORCE_SLOT   = 4'd6,
        OP_FORCE_HANDLE = 4'd7,
        OP_COMPLETE     = 4'd8
    } op_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_START2,
        S_ORD,
        S_FROOT,
        S_ENT1,
        S_ENT2,
        S_FTOP,
        S_FSCAN,
        S_CSCAN,
        S_CEND,
        S_FIN
    } state_t;

    // Datapath commands.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ERR,
        CMD_ALLOC,
        CMD_RES,
        CMD_ORDER,
        CMD_MAP,
        CMD_UNMAP,
        CMD_WAIT,
        CMD_EXEC,
        CMD_ENTER2,
        CMD_FTOP,
        CMD_FSCAN,
        CMD_CSTART,
        CMD_CSCAN,
        CMD_CEND,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } dp_ctrl_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sok;
        phase_t          ph_cur;
        logic            pc_cur_zero;
        logic            res_ok;
        logic            sp_zero;
        logic            sp_one;
        logic            scan_hit;
        logic            scan_last;
        logic            out_free;
    } dp_stat_t;

endpackage

@@ rtl/core/tds_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

@@ rtl/core/tds_ctrl.sv @@
// Controller state machine that sequences the scoreboard datapath.
module tds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tds_pkg::dp_stat_t  stat,
    output tds_pkg::dp_ctrl_t  ctrl
);

    tds_pkg::state_t state_reg;
    tds_pkg::state_t state_next;
    logic            ph_ready;
    logic            ph_low;

    assign ph_ready = (stat.ph_cur == tds_pkg::PH_READY);
    assign ph_low   = (stat.ph_cur == tds_pkg::PH_READY) ||
                      (stat.ph_cur == tds_pkg::PH_WAITING);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tds_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state; every busy state waits while the output register is blocked.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tds_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tds_pkg::S_DEC;
                end
            end
            default:
            begin
                if (stat.out_free)
                begin
                    case (state_reg)
                        tds_pkg::S_DEC:
                        begin
                            case (stat.op)
                                tds_pkg::OP_ORDER_SLOTS, tds_pkg::OP_ORDER_HANDLE:
                                    state_next = (!stat.sok || !ph_ready) ?
                                                 tds_pkg::S_FIN : tds_pkg::S_ORD;
                                tds_pkg::OP_START:
                                    state_next = (!stat.sok || !ph_ready) ?
                                                 tds_pkg::S_FIN : tds_pkg::S_START2;
                                tds_pkg::OP_FORCE_SLOT:
                                    state_next = !stat.sok ? tds_pkg::S_FIN :
                                                 tds_pkg::S_FROOT;
                                tds_pkg::OP_FORCE_HANDLE:
                                    state_next = tds_pkg::S_FROOT;
                                tds_pkg::OP_COMPLETE:
                                    state_next = (!stat.sok ||
                                                  stat.ph_cur != tds_pkg::PH_EXECUTING) ?
                                                 tds_pkg::S_FIN : tds_pkg::S_CSCAN;
                                default:
                                    state_next = tds_pkg::S_FIN;
                            endcase
                        end
                        tds_pkg::S_START2: state_next = tds_pkg::S_FIN;
                        tds_pkg::S_ORD:    state_next = tds_pkg::S_FIN;
                        tds_pkg::S_FROOT:
                            state_next = (stat.res_ok && ph_low) ?
                                         tds_pkg::S_ENT1 : tds_pkg::S_FIN;
                        tds_pkg::S_ENT1:   state_next = tds_pkg::S_ENT2;
                        tds_pkg::S_ENT2:
                            state_next = (stat.pc_cur_zero && stat.sp_zero) ?
                                         tds_pkg::S_FIN : tds_pkg::S_FTOP;
                        tds_pkg::S_FTOP:   state_next = tds_pkg::S_FSCAN;
                        tds_pkg::S_FSCAN:
                        begin
                            if (stat.scan_hit)
                            begin
                                state_next = tds_pkg::S_ENT1;
                            end
                            else if (stat.scan_last)
                            begin
                                state_next = stat.sp_one ? tds_pkg::S_FIN :
                                             tds_pkg::S_FTOP;
                            end
                        end
                        tds_pkg::S_CSCAN:
                        begin
                            if (stat.scan_last)
                            begin
                                state_next = tds_pkg::S_CEND;
                            end
                        end
                        tds_pkg::S_CEND:   state_next = tds_pkg::S_FIN;
                        tds_pkg::S_FIN:    state_next = tds_pkg::S_IDLE;
                        default:           state_next = tds_pkg::S_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        in_ready  = (state_reg == tds_pkg::S_IDLE);
        ctrl.cmd  = tds_pkg::CMD_NONE;
        case (state_reg)
            tds_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.cmd = tds_pkg::CMD_LOAD;
                end
            end
            default:
            begin
                if (stat.out_free)
                begin
                    case (state_reg)
                        tds_pkg::S_DEC:
                        begin
                            case (stat.op)
                                tds_pkg::OP_ATTACH:
                                    ctrl.cmd = tds_pkg::CMD_ALLOC;
                                tds_pkg::OP_ORDER_SLOTS, tds_pkg::OP_ORDER_HANDLE:
                                    ctrl.cmd = (!stat.sok || !ph_ready) ?
                                               tds_pkg::CMD_ERR : tds_pkg::CMD_RES;
                                tds_pkg::OP_MAP:
                                    ctrl.cmd = !stat.sok ? tds_pkg::CMD_ERR :
                                               tds_pkg::CMD_MAP;
                                tds_pkg::OP_UNMAP:
                                    ctrl.cmd = tds_pkg::CMD_UNMAP;
                                tds_pkg::OP_START:
                                    ctrl.cmd = !stat.sok ? tds_pkg::CMD_ERR :
                                               (ph_ready ? tds_pkg::CMD_WAIT :
                                                tds_pkg::CMD_NONE);
                                tds_pkg::OP_FORCE_SLOT:
                                    ctrl.cmd = !stat.sok ? tds_pkg::CMD_ERR :
                                               tds_pkg::CMD_RES;
                                tds_pkg::OP_FORCE_HANDLE:
                                    ctrl.cmd = tds_pkg::CMD_RES;
                                tds_pkg::OP_COMPLETE:
                                    ctrl.cmd = (!stat.sok ||
                                                stat.ph_cur != tds_pkg::PH_EXECUTING) ?
                                               tds_pkg::CMD_ERR : tds_pkg::CMD_CSTART;
                                default:
                                    ctrl.cmd = tds_pkg::CMD_ERR;
                            endcase
                        end
                        tds_pkg::S_START2:
                            ctrl.cmd = stat.pc_cur_zero ? tds_pkg::CMD_EXEC :
                                       tds_pkg::CMD_NONE;
                        tds_pkg::S_ORD:    ctrl.cmd = tds_pkg::CMD_ORDER;
                        tds_pkg::S_ENT1:
                            ctrl.cmd = ph_ready ? tds_pkg::CMD_WAIT : tds_pkg::CMD_NONE;
                        tds_pkg::S_ENT2:   ctrl.cmd = tds_pkg::CMD_ENTER2;
                        tds_pkg::S_FTOP:   ctrl.cmd = tds_pkg::CMD_FTOP;
                        tds_pkg::S_FSCAN:  ctrl.cmd = tds_pkg::CMD_FSCAN;
                        tds_pkg::S_CSCAN:  ctrl.cmd = tds_pkg::CMD_CSCAN;
                        tds_pkg::S_CEND:   ctrl.cmd = tds_pkg::CMD_CEND;
                        tds_pkg::S_FIN:    ctrl.cmd = tds_pkg::CMD_FINISH;
                        default:           ctrl.cmd = tds_pkg::CMD_NONE;
                    endcase
                end
            end
        endcase
    end

endmodule

@@ rtl/core/tds_datapath.sv @@
// Scoreboard datapath: slot state, dependency rows, handle table, stack and result stage.
module tds_datapath #(
    parameter int NUM_SLOTS   = tds_pkg::DEF_NUM_SLOTS,
    parameter int NUM_HANDLES = tds_pkg::DEF_NUM_HANDLES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tds_pkg::dp_ctrl_t                 ctrl,
    output tds_pkg::dp_stat_t                 stat,
    input  logic [tds_pkg::IN_TDATA_W-1:0]    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tds_pkg::OUT_TDATA_W-1:0]   out_data,
    output logic                              out_last
);

    localparam int IW  = $clog2(NUM_SLOTS);
    localparam int SPW = $clog2(NUM_SLOTS + 1);
    localparam int TD  = (NUM_HANDLES > tds_pkg::MAX_TBL_DEPTH) ?
                         tds_pkg::MAX_TBL_DEPTH : NUM_HANDLES;
    localparam int HW  = $clog2(TD);
    localparam int HCW = $clog2(NUM_HANDLES + 1) + 1;

    // Input beat fields.
    logic [tds_pkg::OP_W-1:0]     in_op;
    logic [tds_pkg::SLOT_W-1:0]   in_sid;
    logic [tds_pkg::SLOT_W-1:0]   in_oid;
    logic [tds_pkg::HANDLE_W-1:0] in_h;

    assign in_op  = in_data[3:0];
    assign in_sid = in_data[8:4];
    assign in_oid = in_data[13:9];
    assign in_h   = in_data[21:14];

    // Latched command fields.
    logic [tds_pkg::OP_W-1:0]   op_reg,   op_next;
    logic [tds_pkg::SLOT_W-1:0] sid_reg,  sid_next;
    logic [IW-1:0]              oid_reg,  oid_next;
    logic                       sok_reg,  sok_next;
    logic                       ook_reg,  ook_next;
    logic                       hin_reg,  hin_next;
    logic                       hvrd_reg, hvrd_next;
    logic [HW-1:0]              hidx_reg, hidx_next;

    // Working registers.
    logic [IW-1:0]  cur_reg, cur_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [IW-1:0]  top_reg, top_next;
    logic           res_ok_reg, res_ok_next;
    logic [SPW-1:0] sp_reg, sp_next;

    // Slot state.
    tds_pkg::phase_t          phase_reg [NUM_SLOTS];
    tds_pkg::phase_t          phase_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     pred_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     pred_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     succ_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     succ_next [NUM_SLOTS];
    logic [tds_pkg::CNT_W-1:0] pcnt_reg [NUM_SLOTS];
    logic [tds_pkg::CNT_W-1:0] pcnt_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     free_reg, free_next;
    logic [tds_pkg::CNT_W-1:0] used_reg, used_next;
    logic [IW-1:0]            stack_reg [NUM_SLOTS];
    logic [IW-1:0]            stack_next [NUM_SLOTS];
    logic [TD-1:0]            hvalid_reg, hvalid_next;

    // Result stage: one held result plus the output register.
    logic                       hold_v_reg, hold_v_next;
    tds_pkg::event_t            hold_res_reg, hold_res_next;
    logic [tds_pkg::SLOT_W-1:0] hold_slot_reg, hold_slot_next;
    logic                       out_v_reg, out_v_next;
    tds_pkg::event_t            out_res_reg, out_res_next;
    logic [tds_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic                       out_last_reg, out_last_next;

    // Handle table port.
    logic                      tbl_we;
    logic [tds_pkg::TBL_W-1:0] tbl_wdata;
    logic                      tbl_re;
    logic [tds_pkg::TBL_W-1:0] tbl_rdata;
    logic                      lookup_ok;

    // Combinational helpers.
    logic                 fs_any;
    logic [IW-1:0]        fs;
    tds_pkg::phase_t      ph_cur;
    tds_pkg::phase_t      ph_idx;
    logic                 scan_hit;
    logic                 scan_last;
    logic                 em_v;
    tds_pkg::event_t      em_res;
    logic [tds_pkg::SLOT_W-1:0] em_slot;
    logic [tds_pkg::CNT_W-1:0]  cnt_dec;
    logic [IW-1:0]        sidx;
    logic                 out_free;

    tds_ram #(
        .WIDTH (tds_pkg::TBL_W),
        .DEPTH (TD)
    ) u_tbl (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (hidx_reg),
        .wr_data (tbl_wdata),
        .rd_en   (tbl_re),
        .rd_addr (in_h[HW-1:0]),
        .rd_data (tbl_rdata)
    );

    assign sidx      = sid_reg[IW-1:0];
    assign out_free  = !out_v_reg || out_ready;
    assign lookup_ok = hin_reg && hvrd_reg &&
                       (tbl_rdata < tds_pkg::TBL_W'(NUM_SLOTS));
    assign ph_cur    = ({1'b0, cur_reg} < (IW+1)'(NUM_SLOTS)) ? phase_reg[cur_reg] :
                       tds_pkg::PH_DETACHED;
    assign ph_idx    = ({1'b0, idx_reg} < (IW+1)'(NUM_SLOTS)) ? phase_reg[idx_reg] :
                       tds_pkg::PH_DETACHED;
    assign scan_last = (idx_reg == IW'(NUM_SLOTS - 1));
    assign scan_hit  = pred_reg[top_reg][idx_reg] &&
                       (ph_idx == tds_pkg::PH_READY || ph_idx == tds_pkg::PH_WAITING);
    assign cnt_dec   = pcnt_reg[idx_reg] - tds_pkg::CNT_W'(1);

    // Lowest free slot.
    always_comb
    begin
        fs     = '0;
        fs_any = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                fs     = IW'(i);
                fs_any = 1'b1;
            end
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat.op          = op_reg;
        stat.sok         = sok_reg;
        stat.ph_cur      = ph_cur;
        stat.pc_cur_zero = (pcnt_reg[cur_reg] == '0);
        stat.res_ok      = res_ok_reg;
        stat.sp_zero     = (sp_reg == '0);
        stat.sp_one      = (sp_reg == SPW'(1));
        stat.scan_hit    = scan_hit;
        stat.scan_last   = scan_last;
        stat.out_free    = out_free;
    end

    // Command execution.
    always_comb
    begin
        op_next     = op_reg;
        sid_next    = sid_reg;
        oid_next    = oid_reg;
        sok_next    = sok_reg;
        ook_next    = ook_reg;
        hin_next    = hin_reg;
        hvrd_next   = hvrd_reg;
        hidx_next   = hidx_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        top_next    = top_reg;
        res_ok_next = res_ok_reg;
        sp_next     = sp_reg;
        phase_next  = phase_reg;
        pred_next   = pred_reg;
        succ_next   = succ_reg;
        pcnt_next   = pcnt_reg;
        free_next   = free_reg;
        used_next   = used_reg;
        stack_next  = stack_reg;
        hvalid_next = hvalid_reg;
        tbl_we      = 1'b0;
        tbl_wdata   = tds_pkg::TBL_UNMAPPED;
        tbl_re      = 1'b0;
        em_v        = 1'b0;
        em_res      = tds_pkg::EV_DONE;
        em_slot     = sid_reg;

        case (ctrl.cmd)
            tds_pkg::CMD_LOAD:
            begin
                op_next   = in_op;
                sid_next  = in_sid;
                oid_next  = in_oid[IW-1:0];
                sok_next  = ({1'b0, in_sid} < (tds_pkg::SLOT_W+1)'(NUM_SLOTS));
                ook_next  = ({1'b0, in_oid} < (tds_pkg::SLOT_W+1)'(NUM_SLOTS));
                hin_next  = (HCW'(in_h) < HCW'(NUM_HANDLES));
                hidx_next = in_h[HW-1:0];
                hvrd_next = hvalid_reg[in_h[HW-1:0]];
                cur_next  = in_sid[IW-1:0];
                tbl_re    = 1'b1;
            end
            tds_pkg::CMD_ERR:
            begin
                em_v   = 1'b1;
                em_res = tds_pkg::EV_ERROR;
            end
            tds_pkg::CMD_ALLOC:
            begin
                em_v = 1'b1;
                if (fs_any && used_reg < tds_pkg::CNT_W'(NUM_SLOTS))
                begin
                    free_next[fs]  = 1'b0;
                    used_next      = used_reg + tds_pkg::CNT_W'(1);
                    phase_next[fs] = tds_pkg::PH_READY;
                    pred_next[fs]  = '0;
                    succ_next[fs]  = '0;
                    pcnt_next[fs]  = '0;
                    em_res         = tds_pkg::EV_ALLOC;
                    em_slot        = tds_pkg::SLOT_W'(fs);
                end
                else
                begin
                    em_res  = tds_pkg::EV_FULL;
                    em_slot = '0;
                end
            end
            tds_pkg::CMD_RES:
            begin
                case (op_reg)
                    tds_pkg::OP_ORDER_SLOTS:
                    begin
                        cur_next    = oid_reg;
                        res_ok_next = ook_reg;
                    end
                    tds_pkg::OP_FORCE_SLOT:
                    begin
                        cur_next    = sidx;
                        res_ok_next = 1'b1;
                    end
                    default:
                    begin
                        cur_next    = tbl_rdata[IW-1:0];
                        res_ok_next = lookup_ok;
                    end
                endcase
            end
            tds_pkg::CMD_ORDER:
            begin
                // Ordering by slot also needs the earlier task still live.
                if (res_ok_reg && (op_reg != tds_pkg::OP_ORDER_SLOTS ||
                                   (ph_cur != tds_pkg::PH_COMPLETE &&
                                    ph_cur != tds_pkg::PH_DETACHED)))
                begin
                    if (!pred_reg[sidx][cur_reg])
                    begin
                        pred_next[sidx][cur_reg] = 1'b1;
                        pcnt_next[sidx] = pcnt_reg[sidx] + tds_pkg::CNT_W'(1);
                    end
                    succ_next[cur_reg][sidx] = 1'b1;
                end
            end
            tds_pkg::CMD_MAP:
            begin
                if (hin_reg)
                begin
                    tbl_we                = 1'b1;
                    tbl_wdata             = tds_pkg::TBL_W'(sid_reg);
                    hvalid_next[hidx_reg] = 1'b1;
                end
            end
            tds_pkg::CMD_UNMAP:
            begin
                if (hin_reg)
                begin
                    tbl_we                = 1'b1;
                    hvalid_next[hidx_reg] = 1'b1;
                end
            end
            tds_pkg::CMD_WAIT:
            begin
                phase_next[cur_reg] = tds_pkg::PH_WAITING;
                em_v    = 1'b1;
                em_res  = tds_pkg::EV_WAIT;
                em_slot = tds_pkg::SLOT_W'(cur_reg);
            end
            tds_pkg::CMD_EXEC:
            begin
                phase_next[cur_reg] = tds_pkg::PH_EXECUTING;
                em_v    = 1'b1;
                em_res  = tds_pkg::EV_EXEC;
                em_slot = tds_pkg::SLOT_W'(cur_reg);
            end
            tds_pkg::CMD_ENTER2:
            begin
                if (pcnt_reg[cur_reg] == '0)
                begin
                    phase_next[cur_reg] = tds_pkg::PH_EXECUTING;
                    em_v    = 1'b1;
                    em_res  = tds_pkg::EV_EXEC;
                    em_slot = tds_pkg::SLOT_W'(cur_reg);
                end
                else
                begin
                    phase_next[cur_reg] = tds_pkg::PH_FORCED;
                    if (sp_reg < SPW'(NUM_SLOTS))
                    begin
                        stack_next[sp_reg[IW-1:0]] = cur_reg;
                        sp_next = sp_reg + SPW'(1);
                    end
                end
            end
            tds_pkg::CMD_FTOP:
            begin
                top_next = stack_reg[IW'(sp_reg - SPW'(1))];
                idx_next = '0;
            end
            tds_pkg::CMD_FSCAN:
            begin
                if (scan_hit)
                begin
                    cur_next = idx_reg;
                end
                else if (scan_last)
                begin
                    sp_next = sp_reg - SPW'(1);
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            tds_pkg::CMD_CSTART:
            begin
                phase_next[cur_reg] = tds_pkg::PH_COMPLETE;
                idx_next = '0;
            end
            tds_pkg::CMD_CSCAN:
            begin
                // Release one successor whose predecessor bit is still set.
                if (succ_reg[cur_reg][idx_reg] && pred_reg[idx_reg][cur_reg])
                begin
                    pred_next[idx_reg][cur_reg] = 1'b0;
                    pcnt_next[idx_reg] = cnt_dec;
                    if (cnt_dec == '0 && (ph_idx == tds_pkg::PH_WAITING ||
                                          ph_idx == tds_pkg::PH_FORCED))
                    begin
                        phase_next[idx_reg] = tds_pkg::PH_EXECUTING;
                        em_v    = 1'b1;
                        em_res  = tds_pkg::EV_EXEC;
                        em_slot = tds_pkg::SLOT_W'(idx_reg);
                    end
                end
                idx_next = idx_reg + IW'(1);
            end
            tds_pkg::CMD_CEND:
            begin
                phase_next[cur_reg] = tds_pkg::PH_DETACHED;
                em_v    = 1'b1;
                em_res  = tds_pkg::EV_DISPOSE;
                em_slot = tds_pkg::SLOT_W'(cur_reg);
                if (!free_reg[cur_reg])
                begin
                    free_next[cur_reg] = 1'b1;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - tds_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result staging: a new result pushes the held one out; finish marks the last beat.
    always_comb
    begin
        hold_v_next    = hold_v_reg;
        hold_res_next  = hold_res_reg;
        hold_slot_next = hold_slot_reg;
        out_v_next     = out_v_reg && !out_ready;
        out_res_next   = out_res_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;
        if (ctrl.cmd == tds_pkg::CMD_FINISH)
        begin
            out_v_next    = 1'b1;
            out_last_next = 1'b1;
            out_res_next  = hold_v_reg ? hold_res_reg : tds_pkg::EV_DONE;
            out_slot_next = hold_v_reg ? hold_slot_reg : sid_reg;
            hold_v_next   = 1'b0;
        end
        else if (em_v)
        begin
            if (hold_v_reg)
            begin
                out_v_next    = 1'b1;
                out_last_next = 1'b0;
                out_res_next  = hold_res_reg;
                out_slot_next = hold_slot_reg;
            end
            hold_v_next    = 1'b1;
            hold_res_next  = em_res;
            hold_slot_next = em_slot;
        end
    end

    // Control and slot state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                phase_reg[i] <= tds_pkg::PH_DETACHED;
                pred_reg[i]  <= '0;
                succ_reg[i]  <= '0;
                pcnt_reg[i]  <= '0;
            end
            free_reg   <= '1;
            used_reg   <= '0;
            hvalid_reg <= '0;
            sp_reg     <= '0;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pred_reg   <= pred_next;
            succ_reg   <= succ_next;
            pcnt_reg   <= pcnt_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
            hvalid_reg <= hvalid_next;
            sp_reg     <= sp_next;
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sid_reg       <= sid_next;
        oid_reg       <= oid_next;
        sok_reg       <= sok_next;
        ook_reg       <= ook_next;
        hin_reg       <= hin_next;
        hvrd_reg      <= hvrd_next;
        hidx_reg      <= hidx_next;
        cur_reg       <= cur_next;
        idx_reg       <= idx_next;
        top_reg       <= top_next;
        res_ok_reg    <= res_ok_next;
        stack_reg     <= stack_next;
        hold_res_reg  <= hold_res_next;
        hold_slot_reg <= hold_slot_next;
        out_res_reg   <= out_res_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_v_reg;
    assign out_data  = {out_slot_reg, out_res_reg};
    assign out_last  = out_last_reg;

endmodule

@@ rtl/core/task_dependency_scoreboard_unit.sv @@
// Top level of the task dependency scoreboard.
//
// One command beat enters on the s_axis channel; it yields one or more result
// beats on the m_axis channel, the final one marked by m_axis_tlast.
// Commands are taken one at a time: s_axis_tready is high only while the
// controller is idle, and drops for the whole of a command's work.
// Complete scans the successor row of the slot, one bit checked per cycle
// while the output register is free; force scans the predecessor row of the
// stacked slot one bit a cycle, again unless the output is blocked, and the
// scan restarts from bit zero after each entered predecessor.
// Results pass through one held entry and an output register, so a stalled
// m_axis_tready pauses the command in progress and nothing is lost.
// Reset makes every slot detached and free, clears all dependency rows and
// marks every handle unmapped at once; no clearing pass follows.
module task_dependency_scoreboard_unit #(
    parameter int NUM_SLOTS   = tds_pkg::DEF_NUM_SLOTS,
    parameter int NUM_HANDLES = tds_pkg::DEF_NUM_HANDLES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // op[3:0], slot_id[8:4], other_id[13:9], handle[21:14], zero pad
    input  logic [tds_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // event_res[2:0], event_slot[7:3]
    output logic [tds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    tds_pkg::dp_ctrl_t ctrl;
    tds_pkg::dp_stat_t stat;

    tds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tds_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_HANDLES (NUM_HANDLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

@@ rtl/core/tds_checker.sv @@
// Port-level checker for the scoreboard, bound to the top level.
`include "task_dependency_scoreboard_unit_macros.svh"

module tds_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    logic alloc_or_full;

    assign alloc_or_full = (m_axis_tdata[2:0] == tds_pkg::EV_ALLOC) ||
                           (m_axis_tdata[2:0] == tds_pkg::EV_FULL);

    // A stalled result beat stays and keeps its payload.
    `TDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TDS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // Commands are worked one at a time.
    `TDS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Attach gives exactly one beat, and a full answer names slot zero.
    `TDS_ASSERT_NOW(a_attach_single, m_axis_tvalid && alloc_or_full,
                    m_axis_tlast && (m_axis_tdata[2:0] != tds_pkg::EV_FULL ||
                                     m_axis_tdata[7:3] == '0))

endmodule

bind task_dependency_scoreboard_unit tds_checker u_tds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/task_dependency_scoreboard_unit_tb.sv @@
// Testbench for the task dependency scoreboard: a predictor checks every result beat.
module task_dependency_scoreboard_unit_tb;

    localparam int NSLOT = 32;
    localparam int NHDL = 256;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] handle;
        logic [4:0] other_id;
        logic [4:0] slot_id;
        logic [3:0] op;
    } cmd_beat_t;

    typedef struct packed {
        logic       last;
        logic [4:0] slot;
        logic [2:0] res;
    } ev_beat_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [tds_pkg::IN_TDATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [tds_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    task_dependency_scoreboard_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // Predicted scoreboard state.
    tds_pkg::phase_t sb_phase [NSLOT];
    logic [31:0] sb_free;
    logic [31:0] sb_pred [NSLOT];
    logic [31:0] sb_succ [NSLOT];
    logic [5:0]  sb_pcnt [NSLOT];
    logic [5:0]  sb_scnt [NSLOT];
    logic [5:0]  sb_used;
    logic [5:0]  sb_htab [NHDL];
    logic [4:0]  sb_stack [NSLOT];

    cmd_beat_t pending_cmds[$];
    ev_beat_t  expected_events[$];
    ev_beat_t  step_events[$];
    int        fail_count;
    int        cycle_count;
    int        accept_count;
    int        offer_count;
    bit        calm;
    bit        hold_sender;

    // Clock.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic push_event(input tds_pkg::event_t res, input logic [4:0] slot);
        ev_beat_t e;
        e.res = res;
        e.slot = slot;
        e.last = 1'b0;
        if (step_events.size() < 64)
            step_events.push_back(e);
    endtask

    function automatic logic [5:0] resolve_handle(input logic [7:0] h);
        return (sb_htab[h] < NSLOT) ? sb_htab[h] : tds_pkg::TBL_UNMAPPED;
    endfunction

    task automatic add_dependency(input int later, input int earlier);
        if (!sb_pred[later][earlier])
        begin
            sb_pred[later][earlier] = 1'b1;
            sb_pcnt[later]++;
        end
        if (!sb_succ[earlier][later])
        begin
            sb_succ[earlier][later] = 1'b1;
            sb_scnt[earlier]++;
        end
    endtask

    task automatic enter_forced(input int s, inout int sp);
        if (sb_phase[s] == tds_pkg::PH_READY)
        begin
            sb_phase[s] = tds_pkg::PH_WAITING;
            push_event(tds_pkg::EV_WAIT, 5'(s));
        end
        if (sb_pcnt[s] == 0)
        begin
            sb_phase[s] = tds_pkg::PH_EXECUTING;
            push_event(tds_pkg::EV_EXEC, 5'(s));
        end
        else
        begin
            sb_phase[s] = tds_pkg::PH_FORCED;
            if (sp < NSLOT)
            begin
                sb_stack[sp] = 5'(s);
                sp++;
            end
        end
    endtask

    // Depth-first force through predecessors, lowest slot first.
    task automatic force_tree(input int root);
        int sp;
        int top;
        int hit;
        sp = 0;
        if (sb_phase[root] >= tds_pkg::PH_FORCED)
            return;
        enter_forced(root, sp);
        while (sp > 0)
        begin
            top = int'(sb_stack[sp-1]);
            hit = -1;
            for (int b = 0; b < NSLOT; b++)
                if (hit < 0 && sb_pred[top][b] && sb_phase[b] < tds_pkg::PH_FORCED)
                    hit = b;
            if (hit >= 0)
                enter_forced(hit, sp);
            else
                sp--;
        end
    endtask

    // Completion releases successors, then disposes and frees the slot.
    task automatic complete_task(input int s);
        sb_phase[s] = tds_pkg::PH_COMPLETE;
        for (int k = 0; k < NSLOT; k++)
        begin
            if (sb_succ[s][k] && sb_pred[k][s])
            begin
                sb_pred[k][s] = 1'b0;
                sb_pcnt[k]--;
                if (sb_pcnt[k] == 0 &&
                    (sb_phase[k] == tds_pkg::PH_WAITING || sb_phase[k] == tds_pkg::PH_FORCED))
                begin
                    sb_phase[k] = tds_pkg::PH_EXECUTING;
                    push_event(tds_pkg::EV_EXEC, 5'(k));
                end
            end
        end
        push_event(tds_pkg::EV_DISPOSE, 5'(s));
        sb_phase[s] = tds_pkg::PH_DETACHED;
        if (!sb_free[s])
        begin
            sb_free[s] = 1'b1;
            if (sb_used > 0)
                sb_used--;
        end
    endtask

    // Work out the result beats of one accepted command.
    task automatic predict_events(input cmd_beat_t c);
        int s;
        logic [5:0] m;
        step_events.delete();
        case (c.op)
            tds_pkg::OP_ATTACH:
            begin
                s = -1;
                if (sb_used < NSLOT)
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (sb_free[i])
                            s = i;
                if (s < 0)
                    push_event(tds_pkg::EV_FULL, 5'd0);
                else
                begin
                    sb_free[s] = 1'b0;
                    sb_used++;
                    sb_phase[s] = tds_pkg::PH_READY;
                    sb_pred[s] = '0;
                    sb_succ[s] = '0;
                    sb_pcnt[s] = '0;
                    sb_scnt[s] = '0;
                    push_event(tds_pkg::EV_ALLOC, 5'(s));
                end
            end
            tds_pkg::OP_ORDER_SLOTS, tds_pkg::OP_ORDER_HANDLE:
            begin
                if (sb_phase[c.slot_id] != tds_pkg::PH_READY)
                    push_event(tds_pkg::EV_ERROR, c.slot_id);
                else
                begin
                    if (c.op == tds_pkg::OP_ORDER_SLOTS)
                        m = (sb_phase[c.other_id] < tds_pkg::PH_COMPLETE) ?
                            {1'b0, c.other_id} : tds_pkg::TBL_UNMAPPED;
                    else
                        m = resolve_handle(c.handle);
                    if (m != tds_pkg::TBL_UNMAPPED)
                        add_dependency(int'(c.slot_id), int'(m));
                    push_event(tds_pkg::EV_DONE, c.slot_id);
                end
            end
            tds_pkg::OP_MAP:
            begin
                sb_htab[c.handle] = {1'b0, c.slot_id};
                push_event(tds_pkg::EV_DONE, c.slot_id);
            end
            tds_pkg::OP_UNMAP:
            begin
                sb_htab[c.handle] = tds_pkg::TBL_UNMAPPED;
                push_event(tds_pkg::EV_DONE, c.slot_id);
            end
            tds_pkg::OP_START:
            begin
                if (sb_phase[c.slot_id] == tds_pkg::PH_READY)
                begin
                    sb_phase[c.slot_id] = tds_pkg::PH_WAITING;
                    push_event(tds_pkg::EV_WAIT, c.slot_id);
                    if (sb_pcnt[c.slot_id] == 0)
                    begin
                        sb_phase[c.slot_id] = tds_pkg::PH_EXECUTING;
                        push_event(tds_pkg::EV_EXEC, c.slot_id);
                    end
                end
            end
            tds_pkg::OP_FORCE_SLOT:
                force_tree(int'(c.slot_id));
            tds_pkg::OP_FORCE_HANDLE:
            begin
                m = resolve_handle(c.handle);
                if (m != tds_pkg::TBL_UNMAPPED)
                    force_tree(int'(m));
            end
            tds_pkg::OP_COMPLETE:
            begin
                if (sb_phase[c.slot_id] != tds_pkg::PH_EXECUTING)
                    push_event(tds_pkg::EV_ERROR, c.slot_id);
                else
                    complete_task(int'(c.slot_id));
            end
            default:
                push_event(tds_pkg::EV_ERROR, c.slot_id);
        endcase
        if (step_events.size() == 0)
            push_event(tds_pkg::EV_DONE, c.slot_id);
        step_events[step_events.size()-1].last = 1'b1;
        foreach (step_events[i])
            expected_events.push_back(step_events[i]);
    endtask

    function automatic cmd_beat_t make_cmd(input tds_pkg::op_t op, input int sid,
                                           input int oid, input int h);
        cmd_beat_t c;
        c.op = op;
        c.slot_id = 5'(sid);
        c.other_id = 5'(oid);
        c.handle = 8'(h);
        return c;
    endfunction

    // Random slot biased toward the low, usually allocated slots.
    function automatic int pick_slot();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 9);
    endfunction

    function automatic int pick_handle();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
    endfunction

    // Command driver; changes inputs on the falling edge and holds a beat until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (s_axis_tvalid && accept_count < offer_count)
        begin
            // The offered beat is still waiting.
        end
        else if (pending_cmds.size() > 0 && !hold_sender &&
                 (calm || $urandom_range(0, 99) >= 11))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {2'b00, pending_cmds[0]};
            offer_count++;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // Monitor: accept commands and compare result beats at the rising edge.
    always @(posedge clk)
    begin
        ev_beat_t got;
        ev_beat_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                accept_count++;
                predict_events(pending_cmds.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.res = m_axis_tdata[2:0];
                got.slot = m_axis_tdata[7:3];
                got.last = m_axis_tlast;
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("unexpected beat res %0d slot %0d",
                                              got.res, got.slot));
                else
                begin
                    want = expected_events.pop_front();
                    if (got.res !== want.res)
                        report_mismatch($sformatf("res %0d, want %0d (slot %0d)",
                                                  got.res, want.res, want.slot));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, want %0d",
                                                  got.slot, want.slot));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %0d, want %0d", got.last,
                                                  want.last));
                end
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("task_dependency_scoreboard_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int r;
        int n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        accept_count = 0;
        offer_count = 0;
        calm = 1'b0;
        hold_sender = 1'b0;
        for (int i = 0; i < NSLOT; i++)
        begin
            sb_phase[i] = tds_pkg::PH_DETACHED;
            sb_pred[i] = '0;
            sb_succ[i] = '0;
            sb_pcnt[i] = '0;
            sb_scnt[i] = '0;
            sb_stack[i] = '0;
        end
        for (int i = 0; i < NHDL; i++)
            sb_htab[i] = tds_pkg::TBL_UNMAPPED;
        sb_free = '1;
        sb_used = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a small chain, forcing through predecessors, and odd cases.
        pending_cmds.push_back(make_cmd(tds_pkg::OP_START, 31, 0, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_COMPLETE, 3, 0, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::op_t'(4'd15), 31, 31, 255));
        pending_cmds.push_back(make_cmd(tds_pkg::op_t'(4'd9), 0, 0, 0));
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(make_cmd(tds_pkg::OP_ATTACH, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_ORDER_SLOTS, 1, 0, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_ORDER_SLOTS, 2, 1, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_ORDER_SLOTS, 2, 2, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_ORDER_SLOTS, 3, 31, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_MAP, 0, 0, 255));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_ORDER_HANDLE, 3, 0, 255));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_ORDER_HANDLE, 3, 0, 17));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_MAP, 3, 0, 1));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_FORCE_HANDLE, 0, 0, 1));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_FORCE_SLOT, 2, 0, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_START, 2, 0, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_COMPLETE, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_COMPLETE, 1, 0, 0));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_UNMAP, 0, 0, 255));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_FORCE_HANDLE, 0, 0, 255));
        pending_cmds.push_back(make_cmd(tds_pkg::OP_COMPLETE, 2, 0, 0));

        // Pause the sender until every expected beat has come back.
        wait (pending_cmds.size() == 0);
        hold_sender = 1'b1;
        wait (expected_events.size() == 0);
        hold_sender = 1'b0;

        // Fill the table until full, then drain the lower half.
        for (int i = 0; i < 33; i++)
            pending_cmds.push_back(make_cmd(tds_pkg::OP_ATTACH, 0, 0, 0));
        for (int i = 0; i < 16; i++)
            pending_cmds.push_back(make_cmd(tds_pkg::OP_FORCE_SLOT, i, 0, 0));
        for (int i = 0; i < 16; i++)
            pending_cmds.push_back(make_cmd(tds_pkg::OP_COMPLETE, i, 0, 0));
        wait (pending_cmds.size() == 0);
        calm = 1'b1;

        // Random: mostly well-formed lifecycles with random ordering content.
        n = 0;
        while (n < 36)
        begin
            if (n == 18)
            begin
                wait (pending_cmds.size() == 0);
                calm = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 18)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_ATTACH, $urandom_range(0, 31),
                                                $urandom_range(0, 31), $urandom_range(0, 255)));
            else if (r < 38)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_ORDER_SLOTS, pick_slot(),
                                                pick_slot(), $urandom_range(0, 255)));
            else if (r < 44)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_ORDER_HANDLE, pick_slot(),
                                                pick_slot(), pick_handle()));
            else if (r < 51)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_MAP, pick_slot(), 0, pick_handle()));
            else if (r < 54)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_UNMAP, pick_slot(), 0,
                                                pick_handle()));
            else if (r < 64)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_START, pick_slot(), 0, 0));
            else if (r < 72)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_FORCE_SLOT, pick_slot(), 0, 0));
            else if (r < 77)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_FORCE_HANDLE, 0, 0,
                                                pick_handle()));
            else if (r < 97)
                pending_cmds.push_back(make_cmd(tds_pkg::OP_COMPLETE, pick_slot(), 0, 0));
            else
                pending_cmds.push_back(make_cmd(tds_pkg::op_t'(4'($urandom_range(9, 15))),
                                                $urandom_range(0, 31), $urandom_range(0, 31),
                                                $urandom_range(0, 255)));
            n++;
        end

        wait (pending_cmds.size() == 0);
        wait (expected_events.size() == 0);
        repeat (80) @(posedge clk);
        if (fail_count == 0 && expected_events.size() == 0)
            $display("task_dependency_scoreboard_unit_tb: PASS");
        else
            $display("task_dependency_scoreboard_unit_tb: FAIL");
        $finish;
    end

endmodule
